/* src/vbb_pkg.sv */
// Shared constants and types for the vertical box blur.
package vbb_pkg;

    localparam int PIX_W       = 8;
    localparam int SUM_W       = 12;
    localparam int ROW_W       = 12;
    localparam int IMG_WIDTH_W = 12;
    localparam int HEIGHT_W    = 13;
    localparam int WINDOW_W    = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int MAX_HEIGHT  = 4096;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_WINDOW_DEF = 16;

    localparam logic [IMG_WIDTH_W-1:0] IMAGE_WIDTH_RST  = IMG_WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0]    IMAGE_HEIGHT_RST = HEIGHT_W'(480);
    localparam logic [WINDOW_W-1:0]    WINDOW_LINES_RST = WINDOW_W'(4);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_WINDOW_LINES = 2'd2
    } cfg_reg_t;

endpackage

/* src/vertical_box_blur.sv */
// A result passes through registered stages after its pixel is taken: RAM read, sum, multiply, output.
// Throughput: one pixel per cycle, limited by the read-modify-write of the sum RAM, while m_ready holds.
// A write to window_lines holds s_ready low while the row remainder is rebuilt one row bit
// per cycle; cfg_ready is low over the same span.
// Reset clears counters and pipeline valids and sets the configuration registers to defaults;
// the sum and line RAMs are not cleared and need no clearing pass: row 0 of a frame loads the sums.
module vertical_box_blur
    import vbb_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_pixel,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIX_W-1:0]      m_blurred,
    output logic                  m_frame_end,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WC_W    = $clog2(MAX_WIDTH + 1);
    localparam int SLOT_W  = $clog2(MAX_WINDOW);
    localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
    localparam int K_SHIFT = SUM_W + WIN_W;
    localparam int REC_W   = K_SHIFT + 1;
    localparam int PROD_W  = SUM_W + REC_W;
    localparam int LD_AW   = SLOT_W + COL_W;
    localparam int CNT_W   = $clog2(ROW_W);

    // configuration
    logic [IMG_WIDTH_W-1:0] image_width_reg;
    logic [HEIGHT_W-1:0]    image_height_reg;
    logic [WINDOW_W-1:0]    window_lines_reg;
    logic [WC_W-1:0]        w_c;
    logic [WC_W-1:0]        w_last;
    logic [HEIGHT_W-1:0]    h_c;
    logic [ROW_W-1:0]       h_last;
    logic [WIN_W-1:0]       win_c;

    // raster position
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W:0]   slot_inc;
    logic [SLOT_W:0]   step_t;
    logic [SLOT_W:0]   step_r;
    logic              busy_reg;
    logic [CNT_W-1:0]  bit_cnt_reg;
    logic              row_end;
    logic              frame_last;

    logic accept;
    logic adv;

    // reciprocal table, one entry per window height
    logic [REC_W-1:0] recip_tab [MAX_WINDOW+1];
    logic [REC_W-1:0] recip_reg;

    // pipeline
    logic              s1_valid_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [PIX_W-1:0]  s1_px_reg;
    logic              s1_load_reg;
    logic              s1_sub_reg;
    logic              s1_fe_reg;
    logic              fwd_valid_reg;
    logic [COL_W-1:0]  fwd_col_reg;
    logic [SUM_W-1:0]  fwd_sum_reg;
    logic [SUM_W-1:0]  old_sum;
    logic [SUM_W-1:0]  base_sum;
    logic [SUM_W-1:0]  sub_val;
    logic [SUM_W-1:0]  sum_new;
    logic              s2_valid_reg;
    logic [SUM_W-1:0]  s2_sum_reg;
    logic              s2_fe_reg;
    logic              s3_valid_reg;
    logic [PROD_W-1:0] s3_prod_reg;
    logic              s3_fe_reg;
    logic [SUM_W:0]    q_full;
    logic              m_valid_reg;
    logic [PIX_W-1:0]  m_blurred_reg;
    logic              m_frame_end_reg;

    logic [SUM_W-1:0]  cs_rdata;
    logic [PIX_W-1:0]  ld_rdata;
    logic [LD_AW-1:0]  ld_addr;
    logic              cs_we;

    for (genvar d = 0; d <= MAX_WINDOW; d++) begin : g_recip
        if (d == 0) begin : g_zero
            assign recip_tab[d] = '0;
        end else begin : g_val
            localparam logic [REC_W-1:0] RV = REC_W'(((64'd1 << K_SHIFT) + d - 1) / d);
            assign recip_tab[d] = RV;
        end
    end

    // clamp the registers into their working ranges
    always_comb begin
        if (image_width_reg == '0) begin
            w_c = WC_W'(1);
        end else if (32'(image_width_reg) > MAX_WIDTH) begin
            w_c = WC_W'(MAX_WIDTH);
        end else begin
            w_c = WC_W'(image_width_reg);
        end
        if (image_height_reg == '0) begin
            h_c = HEIGHT_W'(1);
        end else if (32'(image_height_reg) > MAX_HEIGHT) begin
            h_c = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            h_c = image_height_reg;
        end
        if (window_lines_reg == '0) begin
            win_c = WIN_W'(1);
        end else if (32'(window_lines_reg) > MAX_WINDOW) begin
            win_c = WIN_W'(MAX_WINDOW);
        end else begin
            win_c = WIN_W'(window_lines_reg);
        end
        w_last = w_c - WC_W'(1);
        h_last = ROW_W'(h_c - HEIGHT_W'(1));
    end

    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = adv && !busy_reg;
    assign cfg_ready = !busy_reg;
    assign accept    = s_valid && s_ready;

    always_comb begin
        row_end    = WC_W'(col_reg) >= w_last;
        frame_last = row_end && (row_reg >= h_last);
        slot_inc   = {1'b0, slot_reg} + (SLOT_W+1)'(1);
        col_next   = col_reg + COL_W'(1);
        row_next   = row_reg;
        slot_next  = slot_reg;
        if (row_end) begin
            col_next = '0;
            if (frame_last) begin
                row_next  = '0;
                slot_next = '0;
            end else begin
                row_next  = row_reg + ROW_W'(1);
                slot_next = (slot_inc >= (SLOT_W+1)'(win_c)) ? '0 : SLOT_W'(slot_inc);
            end
        end
        // one restoring step of row mod window
        step_t = {slot_reg, row_reg[bit_cnt_reg]};
        step_r = (step_t >= (SLOT_W+1)'(win_c)) ? step_t - (SLOT_W+1)'(win_c) : step_t;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
            window_lines_reg <= WINDOW_LINES_RST;
            col_reg          <= '0;
            row_reg          <= '0;
            slot_reg         <= '0;
            busy_reg         <= 1'b0;
            bit_cnt_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            fwd_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                slot_reg <= slot_next;
            end else if (busy_reg) begin
                slot_reg <= SLOT_W'(step_r);
                if (bit_cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end else begin
                    bit_cnt_reg <= bit_cnt_reg - CNT_W'(1);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_IMAGE_WIDTH: begin
                        image_width_reg <= cfg_data[IMG_WIDTH_W-1:0];
                    end
                    REG_IMAGE_HEIGHT: begin
                        image_height_reg <= cfg_data[HEIGHT_W-1:0];
                    end
                    REG_WINDOW_LINES: begin
                        // rebuild the row remainder for the new window
                        window_lines_reg <= cfg_data[WINDOW_W-1:0];
                        busy_reg         <= 1'b1;
                        bit_cnt_reg      <= CNT_W'(ROW_W - 1);
                        slot_reg         <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (adv) begin
                s1_valid_reg <= accept;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                m_valid_reg  <= s3_valid_reg;
                if (s1_valid_reg) begin
                    fwd_valid_reg <= 1'b1;
                end
            end
        end
    end

    // column sum update, with the last written sum forwarded over the read-first RAM
    always_comb begin
        old_sum  = (fwd_valid_reg && (fwd_col_reg == s1_col_reg)) ? fwd_sum_reg : cs_rdata;
        base_sum = s1_load_reg ? '0 : old_sum;
        sub_val  = s1_sub_reg ? SUM_W'(ld_rdata) : '0;
        sum_new  = base_sum - sub_val + SUM_W'(s1_px_reg);
        q_full   = s3_prod_reg[PROD_W-1:K_SHIFT];
    end

    always_ff @(posedge aclk) begin
        recip_reg <= recip_tab[win_c];
        if (adv) begin
            s1_col_reg  <= col_reg;
            s1_px_reg   <= s_pixel;
            s1_load_reg <= (row_reg == '0);
            s1_sub_reg  <= (row_reg >= ROW_W'(win_c));
            s1_fe_reg   <= frame_last;
            if (s1_valid_reg) begin
                fwd_col_reg <= s1_col_reg;
                fwd_sum_reg <= sum_new;
            end
            s2_sum_reg  <= sum_new;
            s2_fe_reg   <= s1_fe_reg;
            s3_prod_reg <= {{REC_W{1'b0}}, s2_sum_reg} * {{SUM_W{1'b0}}, recip_reg};
            s3_fe_reg   <= s2_fe_reg;
            m_blurred_reg   <= (q_full > (SUM_W+1)'(255)) ? '1 : q_full[PIX_W-1:0];
            m_frame_end_reg <= s3_fe_reg;
        end
    end

    assign cs_we   = adv && s1_valid_reg;
    assign ld_addr = {slot_reg, col_reg};

    vbb_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_sum_ram (
        .aclk  (aclk),
        .we    (cs_we),
        .waddr (s1_col_reg),
        .wdata (sum_new),
        .re    (accept),
        .raddr (col_reg),
        .rdata (cs_rdata)
    );

    vbb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (2 ** LD_AW)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (accept),
        .waddr (ld_addr),
        .wdata (s_pixel),
        .re    (accept),
        .raddr (ld_addr),
        .rdata (ld_rdata)
    );

    assign m_valid     = m_valid_reg;
    assign m_blurred   = m_blurred_reg;
    assign m_frame_end = m_frame_end_reg;

`ifndef SYNTH
    a_slot_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (slot_reg < SLOT_W'(win_c)) || (32'(win_c) == MAX_WINDOW))
        else $error("row slot outside the window");

    a_window_write_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready && (cfg_index == REG_WINDOW_LINES)) |=> !s_ready)
        else $error("item taken while the row remainder is rebuilt");

    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(s3_valid_reg) && $stable(s2_valid_reg)
                                      && $stable(s1_valid_reg))
        else $error("pipeline moved while the output was stalled");
`endif

endmodule

/* src/vbb_ram.sv */
// Simple dual-port RAM, one write port and one registered read port, read-first.
module vbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
